// ----- sv/rsa_modular_exponentiation_core_assert.svh -----
// Assertion macros shared by the RSA modular exponentiation core RTL.
// Depends on nothing; files that assert include it by name.
`ifndef RSA_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RME_ASSERT_AT(label, clk_sig, rstn_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);
`define RME_ASSERT(label, prop, msg) `RME_ASSERT_AT(label, clk, rst_n, prop, msg)
`else
`define RME_ASSERT_AT(label, clk_sig, rstn_sig, prop, msg)
`define RME_ASSERT(label, prop, msg)
`endif
`endif

// ----- sv/rme_pkg.sv -----
// Package for the RSA modular exponentiation core: constants, state and
// command/status types. Depends on nothing.
package rme_pkg;

  localparam int WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_EXP = 2'd2;

  // Command field codes.
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_PROD,
    S_MUL_RED,
    S_SQR_PROD,
    S_SQR_RED,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture a new transaction
    logic mul_prod;  // form acc * base
    logic sqr_prod;  // form base * base
    logic red_step;  // one restoring reduction step
    logic acc_wr;    // write reduced value to the accumulator
    logic base_wr;   // write reduced value to the base, shift the exponent
    logic out_load;  // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
    logic red_last;
    logic out_full;
  } dp_sts_t;

endpackage

// ----- sv/rme_if.sv -----
// Valid/ready channel interfaces of the RSA modular exponentiation core.
// Depends on rme_pkg for the default width.
interface rme_in_if #(parameter int WIDTH = rme_pkg::WIDTH_DEF);
  logic             valid;
  logic             ready;
  logic             command;
  logic [WIDTH-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface rme_out_if #(parameter int WIDTH = rme_pkg::WIDTH_DEF);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ----- sv/rme_datapath.sv -----
// Datapath of the RSA modular exponentiation core: key registers, operand
// registers, multiplier, bit-serial reducer and output register. Uses rme_pkg.
module rme_datapath #(
  parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [WIDTH-1:0]               cfg_wdata,
  input  logic                           in_command,
  input  logic [WIDTH-1:0]               in_value,
  input  rme_pkg::dp_cmd_t               cmd,
  output rme_pkg::dp_sts_t               sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [WIDTH-1:0]               out_result
);
  import rme_pkg::*;

  localparam int PW = 2 * WIDTH;
  localparam int CNT_W = $clog2(PW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PW - 1);

  logic [WIDTH-1:0] mod_r, enc_r, dec_r;
  logic [WIDTH-1:0] acc_r, base_r, exp_r;
  logic [PW-1:0]    prod_r;
  logic [WIDTH-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic [WIDTH-1:0] out_result_r;

  logic [WIDTH-1:0] mult_a;
  logic [PW-1:0]    prod_nxt;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   mod_ext;
  logic [WIDTH:0]   rem_step;
  logic [WIDTH-1:0] rem_nxt;

  // The user must write the key registers only while the core is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= WIDTH'(2);
      enc_r <= WIDTH'(1);
      dec_r <= WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS: mod_r <= cfg_wdata;
        CFG_ENC_EXP: enc_r <= cfg_wdata;
        CFG_DEC_EXP: dec_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mult_a   = cmd.sqr_prod ? base_r : acc_r;
  assign prod_nxt = PW'(mult_a) * PW'(base_r);

  // Restoring reduction: shift in one product bit, subtract the modulus
  // when the partial remainder reaches it.
  assign shifted  = {rem_r, prod_r[PW-1]};
  assign mod_ext  = {1'b0, mod_r};
  assign rem_step = (shifted >= mod_ext) ? (shifted - mod_ext) : shifted;
  assign rem_nxt  = rem_step[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_value;
      acc_r  <= WIDTH'(1);
      exp_r  <= (in_command == CMD_DECRYPT) ? dec_r : enc_r;
    end else begin
      if (cmd.acc_wr) begin
        acc_r <= rem_nxt;
      end
      if (cmd.base_wr) begin
        base_r <= rem_nxt;
        exp_r  <= exp_r >> 1;
      end
    end
    if (cmd.mul_prod || cmd.sqr_prod) begin
      prod_r <= prod_nxt;
      rem_r  <= '0;
    end else if (cmd.red_step) begin
      prod_r <= prod_r << 1;
      rem_r  <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_result_r <= (mod_r == '0) ? '0 : acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul_prod || cmd.sqr_prod) begin
        cnt_r <= '0;
      end else if (cmd.red_step) begin
        cnt_r <= (cnt_r == CNT_LAST) ? '0 : cnt_r + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb  = exp_r[0];
  assign sts.mod_zero = (mod_r == '0);
  assign sts.red_last = (cnt_r == CNT_LAST);
  assign sts.out_full = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- sv/rme_ctrl.sv -----
// Controller of the RSA modular exponentiation core: sequences the
// square-and-multiply steps. Uses rme_pkg and the assertion header.
`include "rsa_modular_exponentiation_core_assert.svh"
module rme_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rme_pkg::dp_sts_t sts,
  output rme_pkg::dp_cmd_t cmd
);
  import rme_pkg::*;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.exp_zero || sts.mod_zero) state_nxt = S_DONE;
        else if (sts.exp_lsb)             state_nxt = S_MUL_PROD;
        else                              state_nxt = S_SQR_PROD;
      end
      S_MUL_PROD: state_nxt = S_MUL_RED;
      S_MUL_RED: begin
        if (sts.red_last) state_nxt = S_SQR_PROD;
      end
      S_SQR_PROD: state_nxt = S_SQR_RED;
      S_SQR_RED: begin
        if (sts.red_last) state_nxt = S_CHECK;
      end
      S_DONE: begin
        if (!sts.out_full) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = in_fire;
    case (state_r)
      S_MUL_PROD: cmd.mul_prod = 1'b1;
      S_SQR_PROD: cmd.sqr_prod = 1'b1;
      S_MUL_RED: begin
        cmd.red_step = 1'b1;
        cmd.acc_wr   = sts.red_last;
      end
      S_SQR_RED: begin
        cmd.red_step = 1'b1;
        cmd.base_wr  = sts.red_last;
      end
      S_DONE:  cmd.out_load = !sts.out_full;
      default: ;
    endcase
  end

  // A result must never overwrite one that the sink has not taken.
  `RME_ASSERT(a_no_overwrite, cmd.out_load |-> !sts.out_full, "result overwritten")
  // An accepted transaction always starts with an exponent check.
  `RME_ASSERT(a_accept_check, in_fire |=> state_r == S_CHECK, "accept did not start")
  // The reduction counter only completes inside a reduction phase.
  `RME_ASSERT(a_red_last_phase,
    sts.red_last |-> (state_r == S_MUL_RED || state_r == S_SQR_RED),
    "reduction end outside reduction")

endmodule

// ----- sv/rsa_modular_exponentiation_core.sv -----
// RSA modular exponentiation core, right-to-left square-and-multiply.
// One transaction at a time: the next one can be accepted in the cycle after the result is loaded.
// Reset (synchronous, active low): idle, no result pending, modulus 2, both exponents 1.
module rsa_modular_exponentiation_core #(
  parameter int WIDTH = rme_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rme_in_if.sink                        in_ch,
  rme_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]              cfg_wdata
);
  import rme_pkg::*;

  // The controller walks the exponent from its low bit. For each bit it
  // optionally multiplies the accumulator by the base, then squares the
  // base; each product is formed by the multiplier and registered, then
  // reduced modulo the modulus one product bit per cycle. A zero exponent
  // or a zero modulus skips straight to the result.
  // A finished result waits in the output register while the next
  // transaction is accepted; a result that finds the register still full
  // holds the controller until the sink takes the older one.
  dp_cmd_t cmd;
  dp_sts_t sts;

  rme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the key registers and the output register, so the
  // result transaction is driven straight from registers.
  rme_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_command (in_ch.command),
    .in_value   (in_ch.value),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_result (out_ch.result)
  );

endmodule
